// File: sv/snrp_pkg.sv
// Package: shared types, character codes and digit decode for the suffix radix parser.
package snrp_pkg;

  // Radix codes as reported on the result
  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  localparam int NUM_RADIX = 4;

  // Base of each radix, indexed by radix code
  localparam logic [4:0] RADIX_BASE [NUM_RADIX] = '{5'd2, 5'd8, 5'd10, 5'd16};

  // ASCII codes used by the decoder
  localparam logic [6:0] CH_0       = 7'h30;
  localparam logic [6:0] CH_9       = 7'h39;
  localparam logic [6:0] CH_UP_A    = 7'h41;
  localparam logic [6:0] CH_UP_F    = 7'h46;
  localparam logic [6:0] CH_LOW_A   = 7'h61;
  localparam logic [6:0] CH_LOW_Z   = 7'h7a;
  localparam logic [6:0] CH_CASE    = 7'h20;
  localparam logic [6:0] CH_SUF_H   = 7'h48;
  localparam logic [6:0] CH_SUF_D   = 7'h44;
  localparam logic [6:0] CH_SUF_O   = 7'h4f;
  localparam logic [6:0] CH_SUF_Q   = 7'h51;
  localparam logic [6:0] CH_SUF_B   = 7'h42;

  // Decoded digit: valid hex digit and its value
  typedef struct packed {
    logic       valid;
    logic [3:0] num;
  } digit_t;

  // Decoded suffix: whether the char is a suffix and which radix
  typedef struct packed {
    logic   hit;
    radix_t radix;
  } suffix_t;

  // Fold lower-case letters onto upper case
  function automatic logic [6:0] to_upper(input logic [6:0] c);
    logic [6:0] u;
    u = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      u = c - CH_CASE;
    end
    return u;
  endfunction

  // Map an upper-case char to a hex digit
  function automatic digit_t decode_digit(input logic [6:0] up);
    digit_t d;
    d.valid = 1'b0;
    d.num   = 4'd0;
    if (up >= CH_0 && up <= CH_9) begin
      d.valid = 1'b1;
      d.num   = 4'(up - CH_0);
    end else if (up >= CH_UP_A && up <= CH_UP_F) begin
      d.valid = 1'b1;
      d.num   = 4'(up - CH_UP_A + 7'd10);
    end
    return d;
  endfunction

  // Map an upper-case char to a radix suffix
  function automatic suffix_t decode_suffix(input logic [6:0] up);
    suffix_t s;
    s.hit   = 1'b1;
    s.radix = RADIX_DEC;
    unique case (up)
      CH_SUF_H:           s.radix = RADIX_HEX;
      CH_SUF_D:           s.radix = RADIX_DEC;
      CH_SUF_O, CH_SUF_Q: s.radix = RADIX_OCT;
      CH_SUF_B:           s.radix = RADIX_BIN;
      default:            s.hit   = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// File: sv/snrp_in_stage.sv
// Input register: captures one character transfer and holds it until the core takes it.
module snrp_in_stage
  import snrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [6:0] s_ch,
  input  logic       s_last,
  input  logic       take,
  output logic       held_valid,
  output logic [6:0] held_up,
  output logic       held_last
);

  logic       in_valid;
  logic [6:0] in_ch;
  logic       in_last;

  // Accept whenever the slot is empty or drains this cycle
  assign s_tready = !in_valid || take;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch   <= s_ch;
      in_last <= s_last;
    end
  end

  assign held_valid = in_valid;
  assign held_up    = to_upper(in_ch);
  assign held_last  = in_last;

endmodule

// File: sv/snrp_accum.sv
// Accumulator bank: one running value and too-large flag per radix, plus the bad-char flag.
module snrp_accum
  import snrp_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [6:0]            up,
  input  logic                  last,
  output logic [VALUE_BITS-1:0] res_value,
  output radix_t                res_radix,
  output logic                  res_bad,
  output logic                  res_too_large
);

  logic [VALUE_BITS-1:0] acc     [NUM_RADIX];
  logic [VALUE_BITS-1:0] acc_fed [NUM_RADIX];
  logic [NUM_RADIX-1:0]  too_large;
  logic [NUM_RADIX-1:0]  too_large_fed;
  logic                  bad_seen;
  logic                  bad_fed;
  digit_t                dig;
  suffix_t               suf;
  logic                  use_suffix;

  assign dig = decode_digit(up);
  assign suf = decode_suffix(up);

  // Only the closing character may be a suffix
  assign use_suffix = last && suf.hit;

  // Feed the digit into every base: scale by a constant and add
  always_comb begin
    logic [VALUE_BITS-1:0] scaled;
    logic [3:0]            d;
    for (int i = 0; i < NUM_RADIX; i++) begin
      case (radix_t'(i))
        RADIX_BIN: scaled = acc[i] << 1;
        RADIX_OCT: scaled = acc[i] << 3;
        RADIX_DEC: scaled = (acc[i] << 3) + (acc[i] << 1);
        default:   scaled = acc[i] << 4;
      endcase
      d = 4'd0;
      too_large_fed[i] = too_large[i];
      if (dig.valid) begin
        if ({1'b0, dig.num} < RADIX_BASE[i]) begin
          d = dig.num;
        end else begin
          too_large_fed[i] = 1'b1;
        end
      end
      acc_fed[i] = scaled + VALUE_BITS'(d);
    end
    bad_fed = bad_seen || !dig.valid;
  end

  // Pick the result for the closing character
  always_comb begin
    if (use_suffix) begin
      res_radix     = suf.radix;
      res_value     = acc[suf.radix];
      res_too_large = too_large[suf.radix];
      res_bad       = bad_seen;
    end else begin
      res_radix     = RADIX_DEC;
      res_value     = acc_fed[RADIX_DEC];
      res_too_large = too_large_fed[RADIX_DEC];
      res_bad       = bad_fed;
    end
  end

  // Advance on each character, clear after the closing one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RADIX; i++) begin
        acc[i] <= '0;
      end
      too_large <= '0;
      bad_seen  <= 1'b0;
    end else if (step) begin
      if (last) begin
        for (int i = 0; i < NUM_RADIX; i++) begin
          acc[i] <= '0;
        end
        too_large <= '0;
        bad_seen  <= 1'b0;
      end else begin
        for (int i = 0; i < NUM_RADIX; i++) begin
          acc[i] <= acc_fed[i];
        end
        too_large <= too_large_fed;
        bad_seen  <= bad_fed;
      end
    end
  end

endmodule

// File: sv/suffix_radix_number_parser.sv
// Top level: suffix radix numeric literal parser with input and result registers.
//
// Takes the characters of one numeric token, one per transfer, with tlast on the
// final character, and gives one result per token. A closing H, D, O/Q or B
// (either case) selects hex, decimal, octal or binary for the earlier digits;
// any other closing character is the last decimal digit. Values wrap modulo
// 2^VALUE_BITS. A new character is taken every cycle unless a closing character
// is stalled: each character is held in the input register until the core takes
// it, and the four per-base accumulators update as it is taken, in the same cycle
// that a closing character's result is loaded into the result register driving
// the master side. The result register lets the next token flow while a result
// waits; only a closing character stalls when the result register is still full.
module suffix_radix_number_parser
  import snrp_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  localparam int OUT_BITS  = ((VALUE_BITS + 2 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [6:0] ch, [7] zero
  input  logic                s_tlast,   // last
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata,   // value, bad_char, digit_too_large, zero fill
  output logic [1:0]          m_tuser    // radix
);

  logic                  held_valid;
  logic [6:0]            held_up;
  logic                  held_last;
  logic                  take;
  logic [VALUE_BITS-1:0] res_value;
  radix_t                res_radix;
  logic                  res_bad;
  logic                  res_too_large;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  radix_t                out_radix;
  logic                  out_bad;
  logic                  out_too_large;

  // Advance unless a closing character finds the result register blocked
  assign take = held_valid && (!held_last || !out_valid || m_tready);

  snrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_ch       (s_tdata[6:0]),
    .s_last     (s_tlast),
    .take       (take),
    .held_valid (held_valid),
    .held_up    (held_up),
    .held_last  (held_last)
  );

  snrp_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .clk           (clk),
    .rst           (rst),
    .step          (take),
    .up            (held_up),
    .last          (held_last),
    .res_value     (res_value),
    .res_radix     (res_radix),
    .res_bad       (res_bad),
    .res_too_large (res_too_large)
  );

  // Result register valid: load on a closing character, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take && held_last) begin
      out_value     <= res_value;
      out_radix     <= res_radix;
      out_bad       <= res_bad;
      out_too_large <= res_too_large;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'({out_too_large, out_bad, out_value});
  assign m_tuser  = out_radix;

endmodule

// File: tb/sv/suffix_radix_number_parser_tb.sv
// Testbench: suffix radix number parser driven over stream handshakes and checked per token.
`timescale 1ns / 1ps

module suffix_radix_number_parser_tb
  import snrp_pkg::*;
();

  localparam int VALUE_W    = 16;
  localparam int OUT_W      = 24;
  localparam int ITEM_COUNT = 750;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  // Expected outcome of one token
  typedef struct {
    logic [VALUE_W-1:0] value;
    radix_t             radix;
    logic               bad_char;
    logic               too_large;
  } literal_result_t;

  // Tracks the four per-base accumulators and queues the outcome of each token
  class literal_scoreboard;
    logic [VALUE_W-1:0] acc [4];
    bit                 too_large [4];
    bit                 bad_seen;
    int unsigned        base_of [4];
    literal_result_t    pending [$];
    int                 errors;
    int                 tokens_checked;
    int                 per_radix [4];
    int                 bad_tokens;
    int                 large_tokens;

    function new();
      base_of = '{2, 8, 10, 16};
      errors = 0;
      tokens_checked = 0;
      per_radix = '{0, 0, 0, 0};
      bad_tokens = 0;
      large_tokens = 0;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < 4; i++) begin
        acc[i] = '0;
        too_large[i] = 1'b0;
      end
      bad_seen = 1'b0;
    endfunction

    // Shift one upper-case digit character into every base
    function void accumulate_digit(logic [6:0] up);
      int unsigned num;
      int unsigned d;
      bit          ok;
      ok = 1'b1;
      num = 0;
      if (up >= CH_0 && up <= CH_9) begin
        num = up - CH_0;
      end else if (up >= CH_UP_A && up <= CH_UP_F) begin
        num = up - CH_UP_A + 10;
      end else begin
        ok = 1'b0;
        bad_seen = 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
        d = 0;
        if (ok) begin
          if (num < base_of[i]) begin
            d = num;
          end else begin
            too_large[i] = 1'b1;
          end
        end
        acc[i] = VALUE_W'(acc[i] * base_of[i] + d);
      end
    endfunction

    // Note one accepted character; a closing one queues the token's outcome
    function void note_char(logic [6:0] ch, bit last);
      logic [6:0]      up;
      radix_t          r;
      bit              is_suffix;
      literal_result_t e;
      up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CH_CASE : ch;
      if (!last) begin
        accumulate_digit(up);
        return;
      end
      is_suffix = 1'b1;
      case (up)
        CH_SUF_H:           r = RADIX_HEX;
        CH_SUF_D:           r = RADIX_DEC;
        CH_SUF_O, CH_SUF_Q: r = RADIX_OCT;
        CH_SUF_B:           r = RADIX_BIN;
        default: begin
          is_suffix = 1'b0;
          r = RADIX_DEC;
        end
      endcase
      if (!is_suffix) accumulate_digit(up);
      e.value = acc[r];
      e.radix = r;
      e.bad_char = bad_seen;
      e.too_large = too_large[r];
      pending.push_back(e);
      clear();
    endfunction

    // Compare one result transfer against the oldest queued outcome
    function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
      literal_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: value %h radix %0d flags %b", $time,
                 data[VALUE_W-1:0], user, data[VALUE_W+1:VALUE_W]);
        errors++;
        return;
      end
      e = pending.pop_front();
      tokens_checked++;
      per_radix[e.radix]++;
      if (e.bad_char) bad_tokens++;
      if (e.too_large) large_tokens++;
      if (data[VALUE_W-1:0] !== e.value) begin
        $display("%0t: value mismatch: expected %h, actual %h", $time, e.value,
                 data[VALUE_W-1:0]);
        errors++;
      end
      if (user !== e.radix) begin
        $display("%0t: radix mismatch: expected %0d, actual %0d", $time, e.radix, user);
        errors++;
      end
      if (data[VALUE_W] !== e.bad_char) begin
        $display("%0t: bad_char mismatch: expected %b, actual %b", $time, e.bad_char,
                 data[VALUE_W]);
        errors++;
      end
      if (data[VALUE_W+1] !== e.too_large) begin
        $display("%0t: digit_too_large mismatch: expected %b, actual %b", $time,
                 e.too_large, data[VALUE_W+1]);
        errors++;
      end
      if (data[OUT_W-1:VALUE_W+2] !== '0) begin
        $display("%0t: fill bits mismatch: expected 0, actual %h", $time,
                 data[OUT_W-1:VALUE_W+2]);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  literal_scoreboard sb = new();
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  ready_steady = 1'b0;
  bit  send_steady = 1'b0;

  suffix_radix_number_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  // Character for a digit value, letters in random case
  function automatic logic [6:0] digit_char(int unsigned v);
    logic [6:0] c;
    if (v < 10) begin
      c = CH_0 + 7'(v);
    end else begin
      c = CH_UP_A + 7'(v - 10);
      if ($urandom_range(0, 1) == 1) c = c + CH_CASE;
    end
    return c;
  endfunction

  // Send one character, holding it until the transfer completes
  task automatic send_char(logic [6:0] ch, bit last);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ch};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(7'(s[i]), i == s.len() - 1);
    end
  endtask

  // One random token: mostly well-formed for a chosen base, some pure noise
  task automatic send_random_token();
    int          n;
    int          sel;
    int unsigned base;
    int unsigned v;
    logic [6:0]  c;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_char(7'($urandom_range(0, 127)), i == n - 1);
      return;
    end
    sel = $urandom_range(0, 5);
    case (sel)
      0: base = 16;
      1: base = 10;
      2, 3: base = 8;
      4: base = 2;
      default: base = 10;
    endcase
    n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        c = 7'($urandom_range(0, 127));
      end else begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, base - 1);
        c = digit_char(v);
      end
      send_char(c, 1'b0);
    end
    // Close with a suffix letter or, for plain decimal, a final digit
    case (sel)
      0: c = CH_SUF_H;
      1: c = CH_SUF_D;
      2: c = CH_SUF_O;
      3: c = CH_SUF_Q;
      4: c = CH_SUF_B;
      default: c = 7'h00;
    endcase
    if (sel == 5) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9);
      c = digit_char(v);
    end else if ($urandom_range(0, 1) == 1) begin
      c = c + CH_CASE;
    end
    send_char(c, 1'b1);
  endtask

  // Check result transfers and drive back-pressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!ready_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) ready_steady = !ready_steady;
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: suffix alone, each base, oversize digits, bad chars, plain decimal
    send_text("H");
    send_text("7fh");
    send_text("12B");
    send_text("9o");
    send_char(7'h00, 1'b0);
    send_char(7'h7f, 1'b0);
    send_char(7'h47, 1'b0);
    send_char(7'h7a, 1'b0);
    send_char(CH_SUF_D + CH_CASE, 1'b1);
    send_text("12345");
    send_text("5A");
    send_text("aQ");

    // Random tokens, some sent back to back
    while (items_sent < ITEM_COUNT) begin
      send_steady = ($urandom_range(0, 4) == 0);
      send_random_token();
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d characters; checked %0d tokens (bin %0d, oct %0d, dec %0d, hex %0d).",
             items_sent, sb.tokens_checked, sb.per_radix[RADIX_BIN], sb.per_radix[RADIX_OCT],
             sb.per_radix[RADIX_DEC], sb.per_radix[RADIX_HEX]);
    $display("Tokens with bad characters: %0d, with oversize digits: %0d.",
             sb.bad_tokens, sb.large_tokens);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: suffix_radix_number_parser.f
sv/snrp_pkg.sv
sv/snrp_in_stage.sv
sv/snrp_accum.sv
sv/suffix_radix_number_parser.sv
tb/sv/suffix_radix_number_parser_tb.sv
